// File: design/sfsu_pkg.sv
// Shared types, constants and helpers for the starfield star update block.
package sfsu_pkg;

    localparam int STAR_COUNT_DEF = 1024;

    localparam logic signed [15:0] CENTRE_X = 16'sd160;
    localparam logic signed [15:0] CENTRE_Y = 16'sd120;
    localparam logic signed [15:0] SCREEN_W = 16'sd320;
    localparam logic signed [15:0] SCREEN_H = 16'sd240;
    localparam logic signed [8:0]  CENTRE_X9 = 9'sd160;
    localparam logic signed [8:0]  CENTRE_Y9 = 9'sd120;
    localparam logic [7:0]         SPAWN_TOP = 8'd255;
    localparam logic [7:0]         X_OFFSET  = 8'd40;
    localparam logic [7:0]         DEPTH_STEP = 8'd2;
    localparam logic [7:0]         DEPTH_MIN  = 8'd1;
    localparam logic [7:0]         GREY_TOP   = 8'd255;

    // Divider: 16 quotient bits, one per cycle
    localparam int DIV_STEPS = 16;

    typedef struct packed {
        logic [7:0] x;
        logic [7:0] y;
        logic [7:0] depth;
    } t_star;

    typedef enum logic [2:0] {
        S_CLEAR,
        S_IDLE,
        S_LOOK,
        S_DIV,
        S_FIN
    } t_state;

    // grey level to RGB565
    function automatic logic [15:0] grey565(input logic [7:0] g);
        grey565 = {g[7:3], g[7:2], g[7:3]};
    endfunction

endpackage

// File: design/sfsu_div.sv
// Bit-serial signed divider: 17-bit signed numerator by 8-bit depth, truncating.
module sfsu_div (
    input  logic                i_clk,
    input  logic                i_rst_n,
    input  logic                i_start,
    input  logic signed [16:0]  i_num,
    input  logic [7:0]          i_den,
    output logic signed [15:0]  o_quot,
    output logic                o_done
);

    localparam int CW = $clog2(sfsu_pkg::DIV_STEPS + 1);

    logic [CW-1:0] r_cnt;
    logic          r_done;
    logic          r_neg;
    logic [7:0]    r_den;
    logic [7:0]    r_rem;
    logic [15:0]   r_quo;
    logic [15:0]   num_mag;
    logic [8:0]    trial;
    logic          fits;

    // magnitude stays below 2^16, so the low 16 bits carry it
    assign num_mag = i_num[16] ? (16'd0 - i_num[15:0]) : i_num[15:0];
    assign trial   = {r_rem, r_quo[15]};
    assign fits    = trial >= {1'b0, r_den};

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cnt  <= '0;
            r_done <= 1'b0;
        end else if (i_start) begin
            r_cnt  <= CW'(sfsu_pkg::DIV_STEPS);
            r_done <= 1'b0;
        end else if (r_cnt != '0) begin
            r_cnt  <= r_cnt - 1'b1;
            r_done <= (r_cnt == CW'(1));
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_start) begin
            r_neg <= i_num[16];
            r_den <= i_den;
            r_rem <= '0;
            r_quo <= num_mag;
        end else if (r_cnt != '0) begin
            r_rem <= fits ? 8'(trial - {1'b0, r_den}) : trial[7:0];
            r_quo <= {r_quo[14:0], fits};
        end
    end

    assign o_quot = $signed(r_neg ? (16'd0 - r_quo) : r_quo);
    assign o_done = r_done;

endmodule

// File: design/starfield_star_update.sv
// Starfield star update: per-star respawn, erase and perspective redraw over a star table.
//
// Each transaction on the input channel names one star slot. The star table (x, y, depth,
// one byte each) sits in a single synchronous RAM with a registered read. A star with depth
// at most 1 respawns (new x, y and a depth from the spawn counter) and produces no pixels.
// Any other star produces an erase pixel and, when it stays alive and on screen, a grey
// draw pixel; last_of_run marks the final pixel of the star. Its four projections run on
// four bit-serial dividers side by side, so a moving star goes through accept, RAM read,
// 16 divider steps, result pickup and write-back. An index at or beyond STAR_COUNT only
// applies frame_start. Up to two output transactions are buffered; a star finishing while
// earlier pixels are still unread waits for them to drain. After reset the block sweeps the
// RAM to zero depth, one entry a cycle, and stalls the input until the sweep ends.
module starfield_star_update #(
    parameter int STAR_COUNT = sfsu_pkg::STAR_COUNT_DEF
) (
    input  logic                i_clk,
    input  logic                i_rst_n,
    // input channel
    input  logic                i_valid,
    output logic                o_stall,
    input  logic [9:0]          i_star_index,
    input  logic                i_frame_start,
    input  logic [7:0]          i_random_x,
    input  logic [7:0]          i_random_y,
    // output channel
    output logic                o_valid,
    input  logic                i_stall,
    output logic signed [15:0]  o_pixel_x,
    output logic signed [15:0]  o_pixel_y,
    output logic [15:0]         o_pixel_color,
    output logic                o_last_of_run
);

    localparam int AW = (STAR_COUNT > 1) ? $clog2(STAR_COUNT) : 1;

    // ---------------------------------------------------------------------------------
    // Star table RAM
    // ---------------------------------------------------------------------------------
    sfsu_pkg::t_star r_mem [STAR_COUNT];
    sfsu_pkg::t_star r_rd;
    logic            mem_we;
    logic [AW-1:0]   mem_waddr;
    sfsu_pkg::t_star mem_wdata;
    logic [31:0]     idx32;
    logic [AW-1:0]   rd_addr;

    assign idx32   = 32'(i_star_index);
    assign rd_addr = idx32[AW-1:0];

    always_ff @(posedge i_clk) begin
        if (mem_we) begin
            r_mem[mem_waddr] <= mem_wdata;
        end
        r_rd <= r_mem[rd_addr];
    end

    // ---------------------------------------------------------------------------------
    // Control state
    // ---------------------------------------------------------------------------------
    sfsu_pkg::t_state r_state, n_state;
    logic [AW-1:0]    r_clr;
    logic [7:0]       r_spawn;
    logic [AW-1:0]    r_addr;
    logic             r_ok;
    logic [7:0]       r_rx;
    logic [7:0]       r_ry;
    sfsu_pkg::t_star  r_star;

    logic in_acc;
    logic div_start;
    logic spawn_dec;
    logic push;
    logic two_res;

    assign o_stall = (r_state != sfsu_pkg::S_IDLE);
    assign in_acc  = i_valid && !o_stall;

    // ---------------------------------------------------------------------------------
    // Projection dividers: (coord - centre) * 256 / depth, old and new depth
    // ---------------------------------------------------------------------------------
    logic signed [8:0]  dx, dy;
    logic signed [16:0] num_x, num_y;
    logic [7:0]         den_old, den_new;
    logic signed [15:0] q_xo, q_yo, q_xn, q_yn;
    logic               d_xo, d_yo, d_xn, d_yn;
    logic               div_done;

    assign dx      = $signed({1'b0, r_rd.x}) - sfsu_pkg::CENTRE_X9;
    assign dy      = $signed({1'b0, r_rd.y}) - sfsu_pkg::CENTRE_Y9;
    assign num_x   = {dx, 8'd0};
    assign num_y   = {dy, 8'd0};
    assign den_old = r_rd.depth;
    assign den_new = r_rd.depth - sfsu_pkg::DEPTH_STEP;

    sfsu_div u_div_xo (.i_clk, .i_rst_n, .i_start(div_start), .i_num(num_x),
                       .i_den(den_old), .o_quot(q_xo), .o_done(d_xo));
    sfsu_div u_div_yo (.i_clk, .i_rst_n, .i_start(div_start), .i_num(num_y),
                       .i_den(den_old), .o_quot(q_yo), .o_done(d_yo));
    sfsu_div u_div_xn (.i_clk, .i_rst_n, .i_start(div_start), .i_num(num_x),
                       .i_den(den_new), .o_quot(q_xn), .o_done(d_xn));
    sfsu_div u_div_yn (.i_clk, .i_rst_n, .i_start(div_start), .i_num(num_y),
                       .i_den(den_new), .o_quot(q_yn), .o_done(d_yn));

    assign div_done = d_xo && d_yo && d_xn && d_yn;

    // ---------------------------------------------------------------------------------
    // Finish stage: screen positions, visibility, colour
    // ---------------------------------------------------------------------------------
    logic signed [15:0] ox, oy, nx, ny;
    logic [7:0]         z_new;
    logic               alive;
    logic               on_screen;
    logic               q_empty;

    assign ox     = q_xo + sfsu_pkg::CENTRE_X;
    assign oy     = q_yo + sfsu_pkg::CENTRE_Y;
    assign nx     = q_xn + sfsu_pkg::CENTRE_X;
    assign ny     = q_yn + sfsu_pkg::CENTRE_Y;
    assign z_new  = r_star.depth - sfsu_pkg::DEPTH_STEP;
    assign alive  = z_new > sfsu_pkg::DEPTH_MIN;
    assign on_screen = (nx >= 16'sd0) && (ny >= 16'sd0) &&
                       (nx < sfsu_pkg::SCREEN_W) && (ny < sfsu_pkg::SCREEN_H);
    assign two_res = alive && on_screen;

    // ---------------------------------------------------------------------------------
    // Sequencer
    // ---------------------------------------------------------------------------------
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= sfsu_pkg::S_CLEAR;
            r_clr   <= '0;
            r_spawn <= sfsu_pkg::SPAWN_TOP;
        end else begin
            r_state <= n_state;
            if (r_state == sfsu_pkg::S_CLEAR) begin
                r_clr <= r_clr + 1'b1;
            end
            if (in_acc && i_frame_start) begin
                r_spawn <= sfsu_pkg::SPAWN_TOP;
            end else if (spawn_dec) begin
                r_spawn <= r_spawn - 1'b1;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (in_acc) begin
            r_addr <= rd_addr;
            r_ok   <= idx32 < 32'(STAR_COUNT);
            r_rx   <= i_random_x;
            r_ry   <= i_random_y;
        end
        if (r_state == sfsu_pkg::S_LOOK) begin
            r_star <= r_rd;
        end
    end

    always_comb begin
        n_state   = r_state;
        mem_we    = 1'b0;
        mem_waddr = r_addr;
        mem_wdata = r_star;
        div_start = 1'b0;
        spawn_dec = 1'b0;
        push      = 1'b0;
        unique case (r_state)
            sfsu_pkg::S_CLEAR: begin
                mem_we    = 1'b1;
                mem_waddr = r_clr;
                mem_wdata = '0;
                if (r_clr == AW'(STAR_COUNT - 1)) begin
                    n_state = sfsu_pkg::S_IDLE;
                end
            end
            sfsu_pkg::S_IDLE: begin
                if (in_acc) begin
                    n_state = sfsu_pkg::S_LOOK;
                end
            end
            sfsu_pkg::S_LOOK: begin
                if (!r_ok) begin
                    n_state = sfsu_pkg::S_IDLE;
                end else if (r_rd.depth <= sfsu_pkg::DEPTH_MIN) begin
                    // respawn: no pixels
                    mem_we          = 1'b1;
                    mem_wdata.x     = r_rx + sfsu_pkg::X_OFFSET;
                    mem_wdata.y     = r_ry;
                    mem_wdata.depth = r_spawn;
                    spawn_dec       = 1'b1;
                    n_state         = sfsu_pkg::S_IDLE;
                end else begin
                    div_start = 1'b1;
                    n_state   = sfsu_pkg::S_DIV;
                end
            end
            sfsu_pkg::S_DIV: begin
                if (div_done) begin
                    n_state = sfsu_pkg::S_FIN;
                end
            end
            sfsu_pkg::S_FIN: begin
                // wait for the output buffer to drain before pushing
                if (q_empty) begin
                    mem_we          = 1'b1;
                    mem_wdata.depth = (alive && !on_screen) ? 8'd0 : z_new;
                    push            = 1'b1;
                    n_state         = sfsu_pkg::S_IDLE;
                end
            end
            default: begin
                n_state = sfsu_pkg::S_IDLE;
            end
        endcase
    end

    // ---------------------------------------------------------------------------------
    // Two-deep output buffer: output register plus one pending draw pixel
    // ---------------------------------------------------------------------------------
    logic               r_out_v;
    logic               r_pend_v;
    logic signed [15:0] r_out_x, r_out_y, r_pend_x, r_pend_y;
    logic [15:0]        r_out_c, r_pend_c;
    logic               r_out_last;
    logic               out_acc;

    assign q_empty = !r_out_v && !r_pend_v;
    assign out_acc = r_out_v && !i_stall;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_v  <= 1'b0;
            r_pend_v <= 1'b0;
        end else if (push) begin
            r_out_v  <= 1'b1;
            r_pend_v <= two_res;
        end else if (out_acc) begin
            r_out_v  <= r_pend_v;
            r_pend_v <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (push) begin
            r_out_x    <= ox;
            r_out_y    <= oy;
            r_out_c    <= '0;
            r_out_last <= !two_res;
            r_pend_x   <= nx;
            r_pend_y   <= ny;
            r_pend_c   <= sfsu_pkg::grey565(sfsu_pkg::GREY_TOP - z_new);
        end else if (out_acc && r_pend_v) begin
            r_out_x    <= r_pend_x;
            r_out_y    <= r_pend_y;
            r_out_c    <= r_pend_c;
            r_out_last <= 1'b1;
        end
    end

    assign o_valid       = r_out_v;
    assign o_pixel_x     = r_out_x;
    assign o_pixel_y     = r_out_y;
    assign o_pixel_color = r_out_c;
    assign o_last_of_run = r_out_last;

endmodule

// File: sim/testbench.sv
// Self-checking testbench for starfield_star_update: predicts respawn/erase/draw pixels per star.
`timescale 1ns / 100ps

module testbench;

    // Run length guard. The slowest legal run is ~1300 stars, each paying block latency,
    // sender gaps and two pixels behind receiver stalls, plus the post-reset table sweep,
    // so this leaves several times the margin.
    localparam int unsigned CYCLE_LIMIT = 400_000;
    // Cycles to let pass after the last expected pixel: a respawn or an idle
    // index produces nothing, so the block may still be busy on one.
    localparam int          SETTLE_CYCLES = 48;

    // Clock and DUT ports; the clock and the DUT inputs are known from time zero
    logic               i_clk         = 1'b0;
    logic               i_rst_n       = 1'b0;
    logic               i_valid       = 1'b0;
    logic               o_stall;
    logic [9:0]         i_star_index  = '0;
    logic               i_frame_start = 1'b0;
    logic [7:0]         i_random_x    = '0;
    logic [7:0]         i_random_y    = '0;
    logic               o_valid;
    logic               i_stall       = 1'b0;
    logic signed [15:0] o_pixel_x;
    logic signed [15:0] o_pixel_y;
    logic [15:0]        o_pixel_color;
    logic               o_last_of_run;

    // One pixel transaction as the output channel carries it
    typedef struct {
        logic signed [15:0] px;
        logic signed [15:0] py;
        logic [15:0]        color;
        logic               last;
    } t_pixel;

    // Shadow copy of the star table and spawn counter
    logic [7:0]  sky_x [sfsu_pkg::STAR_COUNT_DEF];
    logic [7:0]  sky_y [sfsu_pkg::STAR_COUNT_DEF];
    logic [7:0]  sky_z [sfsu_pkg::STAR_COUNT_DEF];
    logic [7:0]  spawn_z;

    t_pixel      pixel_q[$];     // pixels predicted but not yet seen
    t_pixel      want;
    int          mismatches   = 0;
    int unsigned cycle_count  = 0;

    // Idle controls: percent chance of a gap before a star, per-cycle chance
    // of a receiver stall burst; quiet turns both off for the closing stretch.
    int          tx_gap_pct   = 25;
    int          rx_stall_pct = 8;
    bit          quiet        = 1'b0;
    int          stall_left   = 0;

    starfield_star_update dut (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_valid       (i_valid),
        .o_stall       (o_stall),
        .i_star_index  (i_star_index),
        .i_frame_start (i_frame_start),
        .i_random_x    (i_random_x),
        .i_random_y    (i_random_y),
        .o_valid       (o_valid),
        .i_stall       (i_stall),
        .o_pixel_x     (o_pixel_x),
        .o_pixel_y     (o_pixel_y),
        .o_pixel_color (o_pixel_color),
        .o_last_of_run (o_last_of_run)
    );

    always #6 i_clk = ~i_clk;

    // ------------------------------------------------------------------
    // Predictor
    // ------------------------------------------------------------------

    // Perspective projection: (c - centre) * 256 / z + centre, C-style
    // truncating division (SV int division also truncates toward zero).
    function automatic logic signed [15:0] project_coord(input logic [7:0] coord,
                                                         input int centre,
                                                         input logic [7:0] z);
        int offset;
        offset = (int'(coord) - centre) * 256;
        return 16'(offset / int'(z) + centre);
    endfunction

    function automatic void clear_sky();
        for (int i = 0; i < sfsu_pkg::STAR_COUNT_DEF; i++) begin
            sky_x[i] = '0;
            sky_y[i] = '0;
            sky_z[i] = '0;
        end
        spawn_z = sfsu_pkg::SPAWN_TOP;
    endfunction

    // Applies one accepted star transaction to the shadow table and queues
    // the pixels it must produce.
    function automatic void advance_star(input logic [9:0] idx, input logic fs,
                                         input logic [7:0] rx, input logic [7:0] ry);
        logic [7:0]         z;
        logic signed [15:0] ox, oy, nx, ny;
        logic [15:0]        g;
        t_pixel             pix;

        if (fs)
            spawn_z = sfsu_pkg::SPAWN_TOP;
        if (int'(idx) >= sfsu_pkg::STAR_COUNT_DEF)
            return;

        z = sky_z[idx];
        // dead or at the camera: respawn, no pixels
        if (z <= sfsu_pkg::DEPTH_MIN) begin
            sky_x[idx] = rx + sfsu_pkg::X_OFFSET;
            sky_y[idx] = ry;
            sky_z[idx] = spawn_z;
            spawn_z    = spawn_z - 8'd1;
            return;
        end

        // erase at the old depth, then step closer
        ox = project_coord(sky_x[idx], int'(sfsu_pkg::CENTRE_X), z);
        oy = project_coord(sky_y[idx], int'(sfsu_pkg::CENTRE_Y), z);
        z  = z - sfsu_pkg::DEPTH_STEP;
        sky_z[idx] = z;
        pix = '{px: ox, py: oy, color: 16'd0, last: 1'b1};

        // reached the camera: erase only
        if (z <= sfsu_pkg::DEPTH_MIN) begin
            pixel_q.push_back(pix);
            return;
        end

        nx = project_coord(sky_x[idx], int'(sfsu_pkg::CENTRE_X), z);
        ny = project_coord(sky_y[idx], int'(sfsu_pkg::CENTRE_Y), z);
        if (nx >= 0 && ny >= 0 && nx < sfsu_pkg::SCREEN_W && ny < sfsu_pkg::SCREEN_H) begin
            g = 16'(sfsu_pkg::GREY_TOP - z);
            pix.last = 1'b0;
            pixel_q.push_back(pix);
            pix = '{px: nx, py: ny, color: ((g >> 3) << 11) | ((g >> 2) << 5) | (g >> 3),
                    last: 1'b1};
            pixel_q.push_back(pix);
        end else begin
            // left the screen: star dies, erase only
            sky_z[idx] = '0;
            pixel_q.push_back(pix);
        end
    endfunction

    // ------------------------------------------------------------------
    // Output side: receiver stall bursts and the pixel checker
    // ------------------------------------------------------------------

    always @(negedge i_clk) begin
        if (quiet || !i_rst_n) begin
            stall_left = 0;
            i_stall   <= 1'b0;
        end else if (stall_left > 0) begin
            stall_left--;
            i_stall <= 1'b1;
        end else if ($urandom_range(0, 99) < rx_stall_pct) begin
            stall_left = $urandom_range(1, 18) - 1;
            i_stall   <= 1'b1;
        end else begin
            i_stall <= 1'b0;
        end
    end

    // A pixel transaction completes at a rising edge with valid high and stall low.
    always @(posedge i_clk) begin
        if (i_rst_n && o_valid && !i_stall) begin
            if (pixel_q.size() == 0) begin
                $display("%0t: pixel expected none got x=%0d y=%0d color=%h last=%b",
                         $time, o_pixel_x, o_pixel_y, o_pixel_color, o_last_of_run);
                mismatches++;
            end else begin
                want = pixel_q.pop_front();
                if (o_pixel_x !== want.px) begin
                    $display("%0t: pixel_x expected %0d got %0d", $time, want.px, o_pixel_x);
                    mismatches++;
                end
                if (o_pixel_y !== want.py) begin
                    $display("%0t: pixel_y expected %0d got %0d", $time, want.py, o_pixel_y);
                    mismatches++;
                end
                if (o_pixel_color !== want.color) begin
                    $display("%0t: pixel_color expected %h got %h", $time, want.color,
                             o_pixel_color);
                    mismatches++;
                end
                if (o_last_of_run !== want.last) begin
                    $display("%0t: last_of_run expected %b got %b", $time, want.last,
                             o_last_of_run);
                    mismatches++;
                end
            end
        end
    end

    // Hang guard
    always @(posedge i_clk) begin
        cycle_count++;
        if (cycle_count == CYCLE_LIMIT) begin
            $display("FAIL starfield_star_update");
            $finish;
        end
    end

    // ------------------------------------------------------------------
    // Input side
    // ------------------------------------------------------------------

    // Sends one star transaction, with an optional gap in front. Valid stays
    // high after acceptance; the next call or a drain decides what follows.
    task automatic send_star(input logic [9:0] idx, input logic fs,
                             input logic [7:0] rx, input logic [7:0] ry);
        int gap;
        @(negedge i_clk);
        if (!quiet && $urandom_range(0, 99) < tx_gap_pct) begin
            gap = $urandom_range(1, 18);
            i_valid <= 1'b0;
            repeat (gap) @(negedge i_clk);
        end
        i_valid       <= 1'b1;
        i_star_index  <= idx;
        i_frame_start <= fs;
        i_random_x    <= rx;
        i_random_y    <= ry;
        @(posedge i_clk);
        while (o_stall)
            @(posedge i_clk);
        advance_star(idx, fs, rx, ry);
    endtask

    // Sender holds off until every predicted pixel has come back, then lets
    // the block finish any silent star it may still be chewing on.
    task automatic wait_for_pixels_drained();
        @(negedge i_clk);
        i_valid <= 1'b0;
        while (pixel_q.size() != 0)
            @(posedge i_clk);
        repeat (SETTLE_CYCLES) @(posedge i_clk);
    endtask

    // ------------------------------------------------------------------
    // Tests
    // ------------------------------------------------------------------

    // Field extremes, centred star, truncation of negative offsets, off-screen
    // kill, frame_start on both a respawn and a moving star.
    task automatic test_directed();
        // centred star: respawn at depth 255, then erase+draw at the centre
        send_star(10'd0, 1'b1, 8'd120, 8'd120);
        send_star(10'd0, 1'b0, 8'd0, 8'd0);
        send_star(10'd0, 1'b0, 8'd0, 8'd0);
        // top index, all-ones randoms: x wraps to 39, y=255 leaves the screen
        send_star(10'd1023, 1'b0, 8'hFF, 8'hFF);
        send_star(10'd1023, 1'b0, 8'hFF, 8'hFF);
        // dead star respawns; zero randoms give a negative truncated offset
        send_star(10'd1023, 1'b0, 8'h00, 8'h00);
        send_star(10'd1023, 1'b0, 8'h00, 8'h00);
        // frame_start restores the spawn counter on a respawn and on a move
        send_star(10'd5, 1'b1, 8'd110, 8'd130);
        send_star(10'd5, 1'b1, 8'd0, 8'd0);
        send_star(10'd5, 1'b0, 8'd0, 8'd0);
        // alternating bit patterns on index and randoms
        send_star(10'h2AA, 1'b0, 8'hAA, 8'h55);
        send_star(10'h155, 1'b0, 8'h55, 8'hAA);
        send_star(10'h2AA, 1'b0, 8'h00, 8'h00);
        send_star(10'h155, 1'b0, 8'h00, 8'h00);
        send_star(10'h2AA, 1'b0, 8'h00, 8'h00);
        send_star(10'h155, 1'b0, 8'h00, 8'h00);
        // near-edge star: x just inside, survives a few steps
        send_star(10'd7, 1'b0, 8'd20, 8'd20);
        send_star(10'd7, 1'b0, 8'd0, 8'd0);
        send_star(10'd7, 1'b0, 8'd0, 8'd0);
        send_star(10'd7, 1'b0, 8'd0, 8'd0);
        wait_for_pixels_drained();
    endtask

    // Runs the spawn counter through 3, 2, 1, 0 and wraps to 255, then moves
    // the low-depth stars: draw at small depth, erase-only at the camera,
    // immediate respawn of depth 0 and 1.
    task automatic test_spawn_counter_wrap();
        bit centred;
        for (int k = 0; k < 260; k++) begin
            centred = (k >= 246);
            send_star(10'(512 + k), k == 0, centred ? 8'd120 : 8'($urandom),
                      centred ? 8'd120 : 8'($urandom));
        end
        for (int pass = 0; pass < 3; pass++)
            for (int k = 246; k < 260; k++)
                send_star(10'(512 + k), 1'b0, 8'd120, 8'd120);
        wait_for_pixels_drained();
    endtask

    // Random flight: a rotating set of hot slots so stars live long lives,
    // some noise on random slots, rare frame starts, mixed idle settings.
    task automatic test_random_flight();
        logic [9:0] hot [16];
        logic [9:0] idx;
        logic [7:0] rx, ry;
        logic       fs;
        for (int k = 0; k < 16; k++)
            hot[k] = 10'($urandom);
        for (int n = 0; n < 800; n++) begin
            if (n % 100 == 0) begin
                tx_gap_pct   = ($urandom_range(0, 2) == 0) ? 0 : $urandom_range(10, 40);
                rx_stall_pct = ($urandom_range(0, 2) == 0) ? 0 : $urandom_range(3, 12);
                for (int k = 0; k < 4; k++)
                    hot[$urandom_range(0, 15)] = 10'($urandom);
            end
            idx = ($urandom_range(0, 9) == 0) ? 10'($urandom) : hot[$urandom_range(0, 15)];
            fs  = ($urandom_range(0, 49) == 0);
            // half the respawns land near the centre to keep stars alive
            if ($urandom_range(0, 1) == 1) begin
                rx = 8'($urandom_range(100, 140));
                ry = 8'($urandom_range(100, 140));
            end else begin
                rx = 8'($urandom);
                ry = 8'($urandom);
            end
            send_star(idx, fs, rx, ry);
            if (n == 400)
                wait_for_pixels_drained();
        end
        wait_for_pixels_drained();
    endtask

    // Closing stretch with no idling on either side: back-to-back stars.
    task automatic test_steady_stream();
        logic [9:0] hot [8];
        logic [9:0] idx;
        quiet = 1'b1;
        for (int k = 0; k < 8; k++)
            hot[k] = 10'($urandom);
        for (int n = 0; n < 200; n++) begin
            idx = ($urandom_range(0, 7) == 0) ? 10'($urandom) : hot[$urandom_range(0, 7)];
            send_star(idx, $urandom_range(0, 63) == 0, 8'($urandom_range(90, 150)),
                      8'($urandom_range(90, 150)));
        end
    endtask

    // ------------------------------------------------------------------
    // Sequence
    // ------------------------------------------------------------------
    initial begin
        clear_sky();
        repeat (3) @(negedge i_clk);
        i_rst_n <= 1'b1;

        test_directed();
        test_spawn_counter_wrap();
        test_random_flight();
        test_steady_stream();

        wait_for_pixels_drained();
        if (mismatches == 0)
            $display("PASS starfield_star_update");
        else
            $display("FAIL starfield_star_update");
        $finish;
    end

endmodule

// File: files.f
design/sfsu_pkg.sv
design/sfsu_div.sv
design/starfield_star_update.sv
sim/testbench.sv
